>>> rtl/core/fsjm_pkg.sv
// Package for the flow statistics and jitter monitor.
// Holds field widths, the event command codes and default parameter values.
// Has no dependencies; the monitor core takes everything from here by scoped names.
package fsjm_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned PktW    = 32;
  localparam int unsigned ByteW   = 48;
  localparam int unsigned LenW    = 16;
  localparam int unsigned TimeW   = 48;
  localparam int unsigned RsnW    = 3;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned JitW    = 50;
  localparam int unsigned JitOutW = 49;
  localparam int unsigned DelayW  = 64;

  // Smoothing shift of the interarrival jitter estimator (gain of 1/16).
  localparam int unsigned JitShift = 4;

  // Default number of drop counter entries, the last one being the total.
  localparam int unsigned DropReasonsDef = 6;

  // Packed widths of the stream data words, rounded up to whole bytes.
  localparam int unsigned InRawW  = LenW + 2 * TimeW + RsnW;
  localparam int unsigned InDataW = ((InRawW + 7) / 8) * 8;
  localparam int unsigned OutRawW = 4 * PktW + 4 * ByteW + JitOutW + DelayW;
  localparam int unsigned OutDataW = ((OutRawW + 7) / 8) * 8;

  // Event commands; codes above query behave as a query.
  typedef enum logic [CmdW-1:0] {
    CmdTx    = 3'd0,
    CmdRx    = 3'd1,
    CmdDrop  = 3'd2,
    CmdClear = 3'd3,
    CmdQuery = 3'd4
  } cmd_e;

endpackage

>>> rtl/core/flow_stats_jitter_monitor_unit.sv
// Top level of the flow statistics and jitter monitor.
// Depends on fsjm_pkg for widths, command codes and defaults.
// A result is offered after its input transfer has passed the input register and then the result
// register. Throughput: one item per cycle while the result stream is not stalled; the state
// update between the two registers is combinational. Reset (rst_ni low, asynchronous)
// empties both registers, clears all counters, sets first-packet times to all ones and
// selects first-to-last span mode for the active time.
module flow_stats_jitter_monitor_unit #(
  parameter int unsigned DROP_REASONS = fsjm_pkg::DropReasonsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel: continuous_mode.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata from bit 0: byte_count, now_time, sent_time, drop_reason, zero fill.
  input  logic [fsjm_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: command.
  input  logic [fsjm_pkg::CmdW-1:0]     s_axis_tuser,
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata from bit 0: tx_packets, tx_bytes, rx_packets, rx_bytes, lost_packets,
  // jitter, delay_sum, active_time, drop_packets, drop_bytes, zero fill.
  output logic [fsjm_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned PktW   = fsjm_pkg::PktW;
  localparam int unsigned ByteW  = fsjm_pkg::ByteW;
  localparam int unsigned LenW   = fsjm_pkg::LenW;
  localparam int unsigned TimeW  = fsjm_pkg::TimeW;
  localparam int unsigned RsnW   = fsjm_pkg::RsnW;
  localparam int unsigned JitW   = fsjm_pkg::JitW;
  localparam int unsigned DelayW = fsjm_pkg::DelayW;
  localparam int unsigned IdxW   = (DROP_REASONS > 1) ? $clog2(DROP_REASONS) : 1;
  localparam int unsigned CmpW   = ((IdxW > RsnW) ? IdxW : RsnW) + 1;
  localparam logic [CmpW-1:0] NumRsn = CmpW'(DROP_REASONS);
  localparam logic [CmpW-1:0] AllRsn = CmpW'(DROP_REASONS - 1);
  localparam logic [IdxW-1:0] AllIdx = IdxW'(DROP_REASONS - 1);
  localparam int unsigned OutPadW = fsjm_pkg::OutDataW - fsjm_pkg::OutRawW;

  // Input register.
  logic                           in_valid_q;
  logic [fsjm_pkg::CmdW-1:0]      in_cmd_q;
  logic [LenW-1:0]                in_len_q;
  logic [TimeW-1:0]               in_now_q;
  logic signed [TimeW:0]          in_transit_q;
  logic [RsnW-1:0]                in_rsn_q;

  // Result register.
  logic                           out_valid_q, out_valid_d;
  logic [fsjm_pkg::OutDataW-1:0]  out_data_q, out_data_d;

  // Flow state.
  logic                           cont_mode_q;
  logic [PktW-1:0]                tx_pkt_q, tx_pkt_d, rx_pkt_q, rx_pkt_d;
  logic [ByteW-1:0]               tx_byte_q, tx_byte_d, rx_byte_q, rx_byte_d;
  logic [TimeW-1:0]               first_tx_q, first_tx_d, last_tx_q, last_tx_d;
  logic [TimeW-1:0]               first_rx_q, first_rx_d, last_rx_q, last_rx_d;
  logic signed [TimeW:0]          last_transit_q, last_transit_d;
  logic [TimeW-1:0]               reset_moment_q, reset_moment_d;
  logic [JitW-1:0]                jit_q, jit_d;
  logic signed [DelayW-1:0]       delay_q, delay_d;
  logic [PktW-1:0]                drop_pkt_q [DROP_REASONS];
  logic [PktW-1:0]                drop_pkt_d [DROP_REASONS];
  logic [ByteW-1:0]               drop_byte_q [DROP_REASONS];
  logic [ByteW-1:0]               drop_byte_d [DROP_REASONS];

  // Datapath intermediates.
  logic                           fire;
  logic [CmpW-1:0]                rsn_ext;
  logic [IdxW-1:0]                rsn_idx;
  logic                           rsn_single, rsn_known;
  logic [ByteW:0]                 tx_byte_sum, rx_byte_sum, rsn_byte_sum, all_byte_sum;
  logic [PktW-1:0]                rsn_pkt_rd, rsn_pkt_nx, all_pkt_nx;
  logic [ByteW-1:0]               rsn_byte_rd, rsn_byte_nx, all_byte_nx;
  logic signed [TimeW+1:0]        transit_diff;
  logic [JitW-1:0]                jit_mag;
  logic signed [JitW:0]           jit_err, jit_step, jit_sum;
  logic signed [DelayW:0]         delay_sum_w;
  logic [TimeW-1:0]               span_first, span_last, active;
  logic [PktW-1:0]                lost;
  logic [fsjm_pkg::JitOutW-1:0]   jit_out;
  logic [PktW-1:0]                drop_pkt_out;
  logic [ByteW-1:0]               drop_byte_out;

  // Handshakes: the item in the input register moves on when the result register frees up.
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Drop reason decode.
  assign rsn_ext    = CmpW'(in_rsn_q);
  assign rsn_idx    = rsn_ext[IdxW-1:0];
  assign rsn_single = rsn_ext < AllRsn;
  assign rsn_known  = rsn_ext < NumRsn;

  // Saturating sums for the tx, rx and drop byte counters, and the drop packet increments.
  assign tx_byte_sum  = {1'b0, tx_byte_q} + (ByteW + 1)'(in_len_q);
  assign rx_byte_sum  = {1'b0, rx_byte_q} + (ByteW + 1)'(in_len_q);
  assign rsn_pkt_rd   = rsn_single ? drop_pkt_q[rsn_idx] : '0;
  assign rsn_byte_rd  = rsn_single ? drop_byte_q[rsn_idx] : '0;
  assign rsn_byte_sum = {1'b0, rsn_byte_rd} + (ByteW + 1)'(in_len_q);
  assign all_byte_sum = {1'b0, drop_byte_q[AllIdx]} + (ByteW + 1)'(in_len_q);
  assign rsn_pkt_nx   = (&rsn_pkt_rd) ? rsn_pkt_rd : rsn_pkt_rd + PktW'(1);
  assign all_pkt_nx   = (&drop_pkt_q[AllIdx]) ? drop_pkt_q[AllIdx]
                                              : drop_pkt_q[AllIdx] + PktW'(1);
  assign rsn_byte_nx  = rsn_byte_sum[ByteW] ? '1 : rsn_byte_sum[ByteW-1:0];
  assign all_byte_nx  = all_byte_sum[ByteW] ? '1 : all_byte_sum[ByteW-1:0];

  // Jitter: the transit difference is zero on the first receive after a clear.
  // J + ((|D| - J) >>> 4) equals the floor form of J += (|D| - J) / 16 in both directions.
  assign transit_diff = (rx_pkt_q == '0) ? '0
                      : (TimeW + 2)'(in_transit_q) - (TimeW + 2)'(last_transit_q);
  assign jit_mag  = JitW'(transit_diff[TimeW+1] ? -transit_diff : transit_diff);
  assign jit_err  = $signed({1'b0, jit_mag}) - $signed({1'b0, jit_q});
  assign jit_step = jit_err >>> fsjm_pkg::JitShift;
  assign jit_sum  = $signed({1'b0, jit_q}) + jit_step;

  // Delay total with signed saturation.
  assign delay_sum_w = (DelayW + 1)'(delay_q) + (DelayW + 1)'(in_transit_q);

  // State update for the item leaving the input register.
  always_comb begin
    tx_pkt_d       = tx_pkt_q;
    tx_byte_d      = tx_byte_q;
    rx_pkt_d       = rx_pkt_q;
    rx_byte_d      = rx_byte_q;
    first_tx_d     = first_tx_q;
    last_tx_d      = last_tx_q;
    first_rx_d     = first_rx_q;
    last_rx_d      = last_rx_q;
    last_transit_d = last_transit_q;
    reset_moment_d = reset_moment_q;
    jit_d          = jit_q;
    delay_d        = delay_q;
    drop_pkt_d     = drop_pkt_q;
    drop_byte_d    = drop_byte_q;
    if (fire) begin
      unique case (fsjm_pkg::cmd_e'(in_cmd_q))
        fsjm_pkg::CmdTx: begin
          if (tx_pkt_q == '0) begin
            first_tx_d = in_now_q;
          end
          tx_pkt_d  = (&tx_pkt_q) ? tx_pkt_q : tx_pkt_q + PktW'(1);
          tx_byte_d = tx_byte_sum[ByteW] ? '1 : tx_byte_sum[ByteW-1:0];
          last_tx_d = in_now_q;
        end
        fsjm_pkg::CmdRx: begin
          if (rx_pkt_q == '0) begin
            first_rx_d = in_now_q;
          end
          rx_pkt_d       = (&rx_pkt_q) ? rx_pkt_q : rx_pkt_q + PktW'(1);
          rx_byte_d      = rx_byte_sum[ByteW] ? '1 : rx_byte_sum[ByteW-1:0];
          jit_d          = jit_sum[JitW-1:0];
          last_rx_d      = in_now_q;
          last_transit_d = in_transit_q;
          if (delay_sum_w[DelayW] != delay_sum_w[DelayW-1]) begin
            delay_d = delay_sum_w[DelayW] ? {1'b1, {(DelayW-1){1'b0}}}
                                          : {1'b0, {(DelayW-1){1'b1}}};
          end else begin
            delay_d = delay_sum_w[DelayW-1:0];
          end
        end
        fsjm_pkg::CmdDrop: begin
          if (rsn_single) begin
            drop_pkt_d[rsn_idx]  = rsn_pkt_nx;
            drop_byte_d[rsn_idx] = rsn_byte_nx;
          end
          drop_pkt_d[AllIdx]  = all_pkt_nx;
          drop_byte_d[AllIdx] = all_byte_nx;
        end
        fsjm_pkg::CmdClear: begin
          tx_pkt_d       = '0;
          tx_byte_d      = '0;
          rx_pkt_d       = '0;
          rx_byte_d      = '0;
          first_tx_d     = '1;
          last_tx_d      = '0;
          first_rx_d     = '1;
          last_rx_d      = '0;
          last_transit_d = '0;
          reset_moment_d = in_now_q;
          jit_d          = '0;
          delay_d        = '0;
          for (int r = 0; r < DROP_REASONS; r++) begin
            drop_pkt_d[r]  = '0;
            drop_byte_d[r] = '0;
          end
        end
        default: begin
          // Query and unused codes leave the state alone.
        end
      endcase
    end
  end

  // Active time from the updated state.
  always_comb begin
    span_first = (first_tx_d < first_rx_d) ? first_tx_d : first_rx_d;
    span_last  = (last_tx_d > last_rx_d) ? last_tx_d : last_rx_d;
    if (cont_mode_q) begin
      active = (in_now_q >= reset_moment_d) ? in_now_q - reset_moment_d : '0;
    end else if ((tx_pkt_d != '0) || (rx_pkt_d != '0)) begin
      active = (span_last >= span_first) ? span_last - span_first : '0;
    end else begin
      active = '0;
    end
  end

  // Remaining result fields.
  assign lost          = (tx_pkt_d > rx_pkt_d) ? tx_pkt_d - rx_pkt_d : '0;
  assign jit_out       = (jit_d[JitW-1:fsjm_pkg::JitOutW] != '0) ? '1
                                                             : jit_d[fsjm_pkg::JitOutW-1:0];
  assign drop_pkt_out  = rsn_known ? drop_pkt_d[rsn_idx] : '0;
  assign drop_byte_out = rsn_known ? drop_byte_d[rsn_idx] : '0;

  always_comb begin
    if (fire) begin
      out_data_d = {{OutPadW{1'b0}}, drop_byte_out, drop_pkt_out, active, delay_d, jit_out,
                    lost, rx_byte_d, rx_pkt_d, tx_byte_d, tx_pkt_d};
    end else begin
      out_data_d = out_data_q;
    end
  end

  // Control and flow state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      cont_mode_q    <= 1'b0;
      tx_pkt_q       <= '0;
      tx_byte_q      <= '0;
      rx_pkt_q       <= '0;
      rx_byte_q      <= '0;
      first_tx_q     <= '1;
      last_tx_q      <= '0;
      first_rx_q     <= '1;
      last_rx_q      <= '0;
      last_transit_q <= '0;
      reset_moment_q <= '0;
      jit_q          <= '0;
      delay_q        <= '0;
      for (int r = 0; r < DROP_REASONS; r++) begin
        drop_pkt_q[r]  <= '0;
        drop_byte_q[r] <= '0;
      end
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        cont_mode_q <= cfg_data_i;
      end
      tx_pkt_q       <= tx_pkt_d;
      tx_byte_q      <= tx_byte_d;
      rx_pkt_q       <= rx_pkt_d;
      rx_byte_q      <= rx_byte_d;
      first_tx_q     <= first_tx_d;
      last_tx_q      <= last_tx_d;
      first_rx_q     <= first_rx_d;
      last_rx_q      <= last_rx_d;
      last_transit_q <= last_transit_d;
      reset_moment_q <= reset_moment_d;
      jit_q          <= jit_d;
      delay_q        <= delay_d;
      drop_pkt_q     <= drop_pkt_d;
      drop_byte_q    <= drop_byte_d;
    end
  end

  // Input payload register; the transit time now_time - sent_time is formed on capture.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q     <= s_axis_tuser;
      in_len_q     <= s_axis_tdata[LenW-1:0];
      in_now_q     <= s_axis_tdata[LenW +: TimeW];
      in_transit_q <= $signed({1'b0, s_axis_tdata[LenW +: TimeW]})
                    - $signed({1'b0, s_axis_tdata[LenW + TimeW +: TimeW]});
      in_rsn_q     <= s_axis_tdata[LenW + 2 * TimeW +: RsnW];
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

>>> dv/tb_flow_stats_jitter_monitor_unit.sv
// Testbench for flow_stats_jitter_monitor_unit: stream events in, one statistics report out.
// Depends on fsjm_pkg for widths and command codes; predicts every report and checks it.
// Self-contained: directed events, constrained-by-hand random flows, extreme transit times.
module tb_flow_stats_jitter_monitor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Widths taken from the package.
  localparam int unsigned PktW     = fsjm_pkg::PktW;
  localparam int unsigned ByteW    = fsjm_pkg::ByteW;
  localparam int unsigned LenW     = fsjm_pkg::LenW;
  localparam int unsigned TimeW    = fsjm_pkg::TimeW;
  localparam int unsigned RsnW     = fsjm_pkg::RsnW;
  localparam int unsigned CmdW     = fsjm_pkg::CmdW;
  localparam int unsigned JitOutW  = fsjm_pkg::JitOutW;
  localparam int unsigned DelayW   = fsjm_pkg::DelayW;
  localparam int unsigned JitShift = fsjm_pkg::JitShift;
  localparam int unsigned InRawW   = fsjm_pkg::InRawW;
  localparam int unsigned InDataW  = fsjm_pkg::InDataW;
  localparam int unsigned OutDataW = fsjm_pkg::OutDataW;

  // Drop table layout and code limits.
  localparam int unsigned NUM_REASONS    = fsjm_pkg::DropReasonsDef;
  localparam int unsigned TOTAL_IDX      = NUM_REASONS - 1;
  localparam bit [2:0]    REASON_CODE_MAX = 3'd7;
  localparam bit [2:0]    CMD_CODE_MAX    = 3'd7;

  // Saturation limits of the counters.
  localparam bit [63:0] PKT_LIMIT  = 64'hFFFF_FFFF;
  localparam bit [63:0] BYTE_LIMIT = 64'hFFFF_FFFF_FFFF;
  localparam bit [63:0] JIT_LIMIT  = 64'h1_FFFF_FFFF_FFFF;
  localparam bit [47:0] TIME_TOP   = '1;
  localparam longint    DELAY_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint    DELAY_MIN  = 64'sh8000_0000_0000_0000;

  // Report layout: 433 payload bits padded to whole bytes.
  localparam int unsigned REPORT_RAW_W = 4 * PktW + 4 * ByteW + JitOutW + DelayW;
  localparam int unsigned REPORT_W     = ((REPORT_RAW_W + 7) / 8) * 8;

  // One packet event as carried in s_axis_tdata, first field in the low bits.
  typedef struct packed {
    bit [InDataW-InRawW-1:0] fill;
    bit [RsnW-1:0]           drop_reason;
    bit [TimeW-1:0]          sent_time;
    bit [TimeW-1:0]          now_time;
    bit [LenW-1:0]           byte_count;
  } flow_event_t;

  // One statistics report as carried in m_axis_tdata, first field in the low bits.
  typedef struct packed {
    logic [REPORT_W-REPORT_RAW_W-1:0] fill;
    logic [ByteW-1:0]   drop_bytes;
    logic [PktW-1:0]    drop_packets;
    logic [ByteW-1:0]   active_time;
    logic [DelayW-1:0]  delay_sum;
    logic [JitOutW-1:0] jitter;
    logic [PktW-1:0]    lost_packets;
    logic [ByteW-1:0]   rx_bytes;
    logic [PktW-1:0]    rx_packets;
    logic [ByteW-1:0]   tx_bytes;
    logic [PktW-1:0]    tx_packets;
  } flow_report_t;

  // Clock, reset and DUT ports; the driven ones are at known values from time zero.
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_data_i    = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [CmdW-1:0]     s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // Shadow flow state of the monitor.
  bit [63:0] tx_pkts, tx_octets, rx_pkts, rx_octets;
  bit [63:0] first_tx, last_tx, first_rx, last_rx;
  bit [63:0] prev_stamp, clear_moment, jit_est;
  longint    delay_acc;
  bit [63:0] drop_pkts   [NUM_REASONS];
  bit [63:0] drop_octets [NUM_REASONS];
  bit        span_from_clear;

  // Expected reports in order, and run bookkeeping.
  flow_report_t pending_reports[$];
  int           src_idle_pct = 14;
  int           sink_idle_pct = 86;
  int           error_count;
  int           reports_checked;
  int           cmd_tally[8];
  bit [47:0]    flow_clock;

  flow_stats_jitter_monitor_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),    // byte_count, now_time, sent_time, drop_reason, fill
    .s_axis_tuser  (s_axis_tuser),    // command
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)     // tx_packets, tx_bytes, rx_packets, rx_bytes,
                                      // lost_packets, jitter, delay_sum, active_time,
                                      // drop_packets, drop_bytes, fill
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Generous limit on the whole run.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic bit [63:0] sat_add(input bit [63:0] v, input bit [63:0] a,
                                        input bit [63:0] lim);
    return (a > lim - v) ? lim : v + a;
  endfunction

  // Return every counter and time to its cleared value.
  function automatic void clear_flow(input bit [63:0] at);
    tx_pkts = '0;
    tx_octets = '0;
    rx_pkts = '0;
    rx_octets = '0;
    first_tx = 64'(TIME_TOP);
    first_rx = 64'(TIME_TOP);
    last_tx = '0;
    last_rx = '0;
    prev_stamp = '0;
    clear_moment = at;
    jit_est = '0;
    delay_acc = 0;
    for (int r = 0; r < NUM_REASONS; r++) begin
      drop_pkts[r] = '0;
      drop_octets[r] = '0;
    end
  endfunction

  // Apply one accepted event to the shadow state and build the report it yields.
  function automatic flow_report_t predict_report(input bit [2:0] code,
                                                  input flow_event_t ev);
    bit [63:0]    at, stamp, len, pa, pb, mag, first, last, span;
    longint       d;
    int           rsn;
    flow_report_t rep;
    at = 64'(ev.now_time);
    stamp = 64'(ev.sent_time);
    len = 64'(ev.byte_count);
    rsn = ev.drop_reason;
    case (code)
      fsjm_pkg::CmdTx: begin
        if (tx_pkts == 0) first_tx = at;
        tx_pkts = sat_add(tx_pkts, 1, PKT_LIMIT);
        tx_octets = sat_add(tx_octets, len, BYTE_LIMIT);
        last_tx = at;
      end
      fsjm_pkg::CmdRx: begin
        // The first receive seeds the reference, so its transit difference is zero.
        if (rx_pkts == 0) begin
          first_rx = at;
          last_rx = at;
          prev_stamp = stamp;
        end
        rx_pkts = sat_add(rx_pkts, 1, PKT_LIMIT);
        rx_octets = sat_add(rx_octets, len, BYTE_LIMIT);
        pa = at + prev_stamp;
        pb = last_rx + stamp;
        mag = (pa >= pb) ? pa - pb : pb - pa;
        // Smoothed jitter with a gain of 1/16, flooring in both directions.
        if (mag >= jit_est) jit_est += (mag - jit_est) >> JitShift;
        else jit_est -= ((jit_est - mag) + ((64'd1 << JitShift) - 1)) >> JitShift;
        d = longint'(at) - longint'(stamp);
        if (d > 0 && delay_acc > DELAY_MAX - d) delay_acc = DELAY_MAX;
        else if (d < 0 && delay_acc < DELAY_MIN - d) delay_acc = DELAY_MIN;
        else delay_acc += d;
        last_rx = at;
        prev_stamp = stamp;
      end
      fsjm_pkg::CmdDrop: begin
        // Total and unknown reasons count only once, into the total entry.
        if (rsn < TOTAL_IDX) begin
          drop_pkts[rsn] = sat_add(drop_pkts[rsn], 1, PKT_LIMIT);
          drop_octets[rsn] = sat_add(drop_octets[rsn], len, BYTE_LIMIT);
        end
        drop_pkts[TOTAL_IDX] = sat_add(drop_pkts[TOTAL_IDX], 1, PKT_LIMIT);
        drop_octets[TOTAL_IDX] = sat_add(drop_octets[TOTAL_IDX], len, BYTE_LIMIT);
      end
      fsjm_pkg::CmdClear: clear_flow(at);
      default: begin
        // Query and unknown codes leave the state alone.
      end
    endcase

    // Active time depends on the mode; negative spans read as zero.
    if (span_from_clear) begin
      span = (at >= clear_moment) ? at - clear_moment : 0;
    end else if (tx_pkts != 0 || rx_pkts != 0) begin
      first = (first_tx < first_rx) ? first_tx : first_rx;
      last = (last_tx > last_rx) ? last_tx : last_rx;
      span = (last >= first) ? last - first : 0;
    end else begin
      span = 0;
    end

    rep = '0;
    rep.tx_packets = tx_pkts[PktW-1:0];
    rep.tx_bytes = tx_octets[ByteW-1:0];
    rep.rx_packets = rx_pkts[PktW-1:0];
    rep.rx_bytes = rx_octets[ByteW-1:0];
    rep.lost_packets = (tx_pkts > rx_pkts) ? PktW'(tx_pkts - rx_pkts) : '0;
    rep.jitter = (jit_est > JIT_LIMIT) ? JIT_LIMIT[JitOutW-1:0] : jit_est[JitOutW-1:0];
    rep.delay_sum = delay_acc;
    rep.active_time = (span > BYTE_LIMIT) ? BYTE_LIMIT[ByteW-1:0] : span[ByteW-1:0];
    if (rsn < NUM_REASONS) begin
      rep.drop_packets = drop_pkts[rsn][PktW-1:0];
      rep.drop_bytes = drop_octets[rsn][ByteW-1:0];
    end
    return rep;
  endfunction

  function automatic flow_event_t make_event(input bit [15:0] len, input bit [47:0] at,
                                             input bit [47:0] stamp, input bit [2:0] rsn);
    flow_event_t ev;
    ev = '0;
    ev.byte_count = len;
    ev.now_time = at;
    ev.sent_time = stamp;
    ev.drop_reason = rsn;
    return ev;
  endfunction

  function automatic bit [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Send one event; the expectation is recorded at the edge of its transfer.
  task automatic send_event(input bit [2:0] code, input flow_event_t ev);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= code;
    s_axis_tdata <= ev;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_reports.push_back(predict_report(code, ev));
    cmd_tally[code]++;
  endtask

  // Stop sending and wait until every expected report has come back.
  task automatic drain_flow();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write continuous_mode; only called with the monitor idle.
  task automatic write_mode(input bit value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    span_from_clear = value;
  endtask

  // Check each report transfer against the oldest expectation.
  always @(posedge clk_i) begin : report_checker
    flow_report_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = flow_report_t'(REPORT_W'(m_axis_tdata));
      if (pending_reports.size() == 0) begin
        error_count++;
        $display("%0t: report transfer with nothing expected, expected none, actual 0x%0h",
                 $time, m_axis_tdata);
      end else begin
        want = pending_reports.pop_front();
        compare_field("tx_packets", want.tx_packets, got.tx_packets);
        compare_field("tx_bytes", want.tx_bytes, got.tx_bytes);
        compare_field("rx_packets", want.rx_packets, got.rx_packets);
        compare_field("rx_bytes", want.rx_bytes, got.rx_bytes);
        compare_field("lost_packets", want.lost_packets, got.lost_packets);
        compare_field("jitter", want.jitter, got.jitter);
        compare_field("delay_sum", want.delay_sum, got.delay_sum);
        compare_field("active_time", want.active_time, got.active_time);
        compare_field("drop_packets", want.drop_packets, got.drop_packets);
        compare_field("drop_bytes", want.drop_bytes, got.drop_bytes);
        reports_checked++;
      end
    end
    m_axis_tready <= (sink_idle_pct == 0) || ($urandom_range(99) >= sink_idle_pct);
  end

  // Field extremes, every command and the corner cases in span mode.
  task automatic test_directed_events();
    send_event(fsjm_pkg::CmdQuery, make_event(16'd0, 48'd0, 48'd0, 3'(TOTAL_IDX)));
    send_event(fsjm_pkg::CmdTx, make_event(16'd0, 48'd100, 48'd0, 3'd0));
    send_event(fsjm_pkg::CmdTx, make_event(16'hFFFF, 48'd200, TIME_TOP, 3'd1));
    // First receive, then a huge transit jump and a receive from the future.
    send_event(fsjm_pkg::CmdRx, make_event(16'd1500, 48'd300, 48'd250, 3'd2));
    send_event(fsjm_pkg::CmdRx, make_event(16'hFFFF, TIME_TOP, 48'd0, 3'd3));
    send_event(fsjm_pkg::CmdRx, make_event(16'd64, 48'd0, TIME_TOP, 3'd4));
    for (int r = 0; r < TOTAL_IDX; r++)
      send_event(fsjm_pkg::CmdDrop, make_event(16'(100 * (r + 1)), 48'd400, 48'd0, 3'(r)));
    send_event(fsjm_pkg::CmdDrop, make_event(16'hFFFF, 48'd410, 48'd0, 3'(TOTAL_IDX)));
    send_event(fsjm_pkg::CmdDrop, make_event(16'd7, 48'd420, 48'd0, REASON_CODE_MAX));
    // Reasons past the table read back as zero.
    send_event(fsjm_pkg::CmdQuery, make_event(16'd0, 48'd430, 48'd0, 3'(TOTAL_IDX + 1)));
    send_event(fsjm_pkg::CmdQuery, make_event(16'd0, 48'd440, 48'd0, REASON_CODE_MAX));
    send_event(3'(fsjm_pkg::CmdQuery + 1), make_event(16'd5, 48'd450, 48'd1, 3'd0));
    send_event(CMD_CODE_MAX, make_event(16'hFFFF, TIME_TOP, TIME_TOP, 3'(TOTAL_IDX)));
    send_event(fsjm_pkg::CmdClear, make_event(16'd0, 48'd5000, 48'd0, 3'(TOTAL_IDX)));
    send_event(fsjm_pkg::CmdQuery, make_event(16'd0, 48'd6000, 48'd0, 3'(TOTAL_IDX)));
  endtask

  // Active time since the last clear, including time running backwards.
  task automatic test_continuous_mode();
    drain_flow();
    write_mode(1'b1);
    send_event(fsjm_pkg::CmdClear, make_event(16'd0, 48'd1000, 48'd0, 3'd0));
    send_event(fsjm_pkg::CmdQuery, make_event(16'd0, 48'd500, 48'd0, 3'd0));
    send_event(fsjm_pkg::CmdTx, make_event(16'd60, 48'd1700, 48'd0, 3'd0));
    send_event(fsjm_pkg::CmdQuery, make_event(16'd0, TIME_TOP, 48'd0, 3'(TOTAL_IDX)));
  endtask

  // Mostly well-formed flows on a running clock, with some noise mixed in.
  task automatic test_random_traffic(input int count, input int src_pct,
                                     input int sink_pct, input bit mode);
    int          pick, len_sel;
    bit [2:0]    code;
    flow_event_t ev;
    drain_flow();
    write_mode(mode);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    flow_clock = rand48();
    for (int i = 0; i < count; i++) begin
      // At least once per phase the sender holds off until the monitor is empty.
      if (i == count / 2 || $urandom_range(199) == 0) drain_flow();
      if ($urandom_range(19) == 0) flow_clock = rand48();
      else if ($urandom_range(29) == 0) flow_clock -= 48'($urandom_range(5000));
      else flow_clock += 48'($urandom_range(2000));
      ev = '0;
      ev.now_time = flow_clock;
      ev.sent_time = flow_clock - 48'($urandom_range(5000));
      ev.drop_reason = 3'($urandom_range(TOTAL_IDX));
      len_sel = $urandom_range(9);
      ev.byte_count = (len_sel == 0) ? 16'd0 : (len_sel == 1) ? 16'hFFFF :
                      (len_sel == 2) ? 16'($urandom) : 16'($urandom_range(1518, 64));
      pick = $urandom_range(99);
      if (pick < 30) begin
        code = fsjm_pkg::CmdTx;
      end else if (pick < 65) begin
        code = fsjm_pkg::CmdRx;
        if ($urandom_range(15) == 0) ev.sent_time = rand48();
      end else if (pick < 80) begin
        code = fsjm_pkg::CmdDrop;
        if ($urandom_range(7) == 0)
          ev.drop_reason = 3'($urandom_range(REASON_CODE_MAX, TOTAL_IDX));
      end else if (pick < 88) begin
        code = fsjm_pkg::CmdQuery;
        if ($urandom_range(7) == 0)
          ev.drop_reason = 3'($urandom_range(REASON_CODE_MAX, TOTAL_IDX));
      end else if (pick < 91) begin
        code = fsjm_pkg::CmdClear;
      end else if (pick < 95) begin
        code = 3'($urandom_range(CMD_CODE_MAX, fsjm_pkg::CmdQuery + 1));
      end else begin
        code = 3'($urandom_range(CMD_CODE_MAX));
        ev.byte_count = 16'($urandom);
        ev.now_time = rand48();
        ev.sent_time = rand48();
        ev.drop_reason = 3'($urandom_range(REASON_CODE_MAX));
      end
      send_event(code, ev);
    end
  endtask

  // Receives with the largest transit times of both signs, back to back.
  task automatic test_extreme_transits();
    drain_flow();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    send_event(fsjm_pkg::CmdClear, make_event(16'd0, 48'd0, 48'd0, 3'd0));
    for (int i = 0; i < 16; i++)
      send_event(fsjm_pkg::CmdRx, make_event(16'd64, TIME_TOP, 48'd0, 3'd0));
    send_event(fsjm_pkg::CmdClear, make_event(16'd0, 48'd0, 48'd0, 3'd0));
    for (int i = 0; i < 16; i++)
      send_event(fsjm_pkg::CmdRx, make_event(16'd64, 48'd0, TIME_TOP, 3'd0));
  endtask

  // Test sequence.
  initial begin
    span_from_clear = 1'b0;
    clear_flow(64'd0);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_events();
    test_continuous_mode();
    test_random_traffic(400, 14, 86, 1'b0);
    test_random_traffic(400, 86, 14, 1'b1);
    test_random_traffic(400, 0, 0, 1'b0);
    test_extreme_transits();
    drain_flow();
    $display("Covered %0d events: %0d tx, %0d rx, %0d drop, %0d clear, %0d query or unknown.",
             cmd_tally.sum(), cmd_tally[fsjm_pkg::CmdTx], cmd_tally[fsjm_pkg::CmdRx],
             cmd_tally[fsjm_pkg::CmdDrop], cmd_tally[fsjm_pkg::CmdClear],
             cmd_tally.sum() - cmd_tally[fsjm_pkg::CmdTx] - cmd_tally[fsjm_pkg::CmdRx] -
             cmd_tally[fsjm_pkg::CmdDrop] - cmd_tally[fsjm_pkg::CmdClear]);
    $display("Checked %0d reports in both active-time modes, with extreme transit times.",
             reports_checked);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/fsjm_pkg.sv
rtl/core/flow_stats_jitter_monitor_unit.sv
dv/tb_flow_stats_jitter_monitor_unit.sv
